@@ hw/rtl/cml_pkg.sv @@
// Shared widths, codes and constants of the color matching lookup unit.
package cml_pkg;

    localparam int WL_W       = 18;   // wavelength, nm with 8 fraction bits
    localparam int VAL_W      = 16;   // curve value, unsigned Q2.14
    localparam int ROW_IDX_W  = 7;    // row index field of a write word
    localparam int CURVE_W    = 2;
    localparam int NUM_CURVES = 3;
    localparam int CFG_IDX_W  = 1;

    localparam int TABLE_ROWS_DEF = 128;

    // Operation codes carried in the slave-side tuser.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Curve codes.
    localparam logic [CURVE_W-1:0] CURVE_X = 2'd0;
    localparam logic [CURVE_W-1:0] CURVE_Y = 2'd1;
    localparam logic [CURVE_W-1:0] CURVE_Z = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WL = 1'b1;

    localparam logic [WL_W-1:0] MIN_WL_RESET = 18'd92160;   // 360 nm
    localparam logic [WL_W-1:0] MAX_WL_RESET = 18'd212480;  // 830 nm

    // One table step is 5 nm = 1280 in wavelength units.
    localparam int              FRAC_W     = 8;
    localparam int              STEP_HI_W  = WL_W - FRAC_W;     // 10
    localparam int              REM_W      = 11;               // 0..1279
    localparam logic [REM_W-1:0] STEP_FIXED = 11'd1280;

    // Divide by 5 through reciprocals: (x * 205) >> 10 for x < 1024,
    // (x * 419431) >> 21 for x < 2^19.
    localparam int                   ROW_Q_W      = 8;
    localparam int                   HI_PROD_W    = 18;
    localparam logic [HI_PROD_W-1:0] RECIP5_HI    = 18'd205;
    localparam int                   RECIP5_HI_SH = 10;
    localparam int                   PROD_W       = 27;
    localparam int                   SCALED_W     = PROD_W - FRAC_W;  // 19
    localparam int                   QMUL_W       = 2 * SCALED_W;     // 38
    localparam logic [QMUL_W-1:0]    RECIP5_LO    = 38'd419431;
    localparam int                   RECIP5_LO_SH = 21;

endpackage

@@ hw/rtl/color_matching_lookup_unit.sv @@
// Color matching table with three curves and linear interpolation between 5 nm rows.
// Throughput: one word per cycle unless the master side stalls, lookups and table
// writes alike; each word takes one access slot of the curve memories, whose single
// read/write port paces the pipeline. Table writes land in that same memory stage, so
// a lookup right after a write sees it.
// Reset (synchronous, active low) empties the pipeline and loads the default range;
// the table memories keep their contents and are undefined until written.
module color_matching_lookup_unit #(
    parameter int TABLE_ROWS = cml_pkg::TABLE_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: wavelength[17:0], row_index[24:18], curve_select[26:25],
    //        table_value[42:27], zero fill [47:43]
    input  logic [47:0]                   i_s_tdata,
    // tuser: operation[0]
    input  logic                          i_s_tuser,
    // master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: x_value[15:0], y_value[31:16], z_value[47:32]
    output logic [47:0]                   o_m_tdata,
    // tuser: in_range[0]
    output logic                          o_m_tuser,
    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [cml_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cml_pkg::WL_W-1:0]      i_cfg_data
);

    localparam int RW  = ($clog2(TABLE_ROWS) < 2) ? 2 : $clog2(TABLE_ROWS);
    localparam int WXW = (RW > cml_pkg::ROW_IDX_W) ? RW : cml_pkg::ROW_IDX_W;
    localparam int QXW = (RW > cml_pkg::ROW_Q_W) ? RW : cml_pkg::ROW_Q_W;
    localparam int NC  = cml_pkg::NUM_CURVES;

    // ---------------------------------------------------------------- input unpack
    logic [cml_pkg::WL_W-1:0]      in_wl;
    logic [cml_pkg::ROW_IDX_W-1:0] in_row;
    logic [cml_pkg::CURVE_W-1:0]   in_curve;
    logic [cml_pkg::VAL_W-1:0]     in_val;
    logic [WXW-1:0]                in_row_ext;

    assign in_wl      = i_s_tdata[17:0];
    assign in_row     = i_s_tdata[24:18];
    assign in_curve   = i_s_tdata[26:25];
    assign in_val     = i_s_tdata[42:27];
    assign in_row_ext = WXW'(in_row);

    // ---------------------------------------------------------------- config registers
    logic [cml_pkg::WL_W-1:0] r_min_wl;
    logic [cml_pkg::WL_W-1:0] r_max_wl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_wl <= cml_pkg::MIN_WL_RESET;
            r_max_wl <= cml_pkg::MAX_WL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                cml_pkg::REG_MIN_WL: r_min_wl <= i_cfg_data;
                cml_pkg::REG_MAX_WL: r_max_wl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- stage control
    // Each stage advances when it is empty or the next one advances, so bubbles
    // collapse and a waiting result never blocks the slave side on its own.
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_out_valid;
    logic en1, en2, en3, en4, en_out;
    logic accept;

    assign en_out     = !r_out_valid || i_m_tready;
    assign en4        = !r_s4_valid || en_out;
    assign en3        = !r_s3_valid || en4;
    assign en2        = !r_s2_valid || en3;
    assign en1        = !r_s1_valid || en2;
    assign o_s_tready = en1;
    assign accept     = i_s_tvalid && en1;

    // ---------------------------------------------------------------- stage 1
    // Range check and offset from the table start. Drop bad writes here.
    logic in_wr_ok;
    logic in_is_wr;
    logic [cml_pkg::WL_W-1:0] in_off;

    assign in_is_wr = (i_s_tuser == cml_pkg::OP_WRITE);
    assign in_wr_ok = (in_curve == cml_pkg::CURVE_X || in_curve == cml_pkg::CURVE_Y ||
                       in_curve == cml_pkg::CURVE_Z) &&
                      (32'(in_row) < 32'(TABLE_ROWS));
    assign in_off   = in_wl - r_min_wl;

    logic                            r_s1_wr;
    logic                            r_s1_ok;
    logic [cml_pkg::STEP_HI_W-1:0]   r_s1_hi;
    logic [cml_pkg::FRAC_W-1:0]      r_s1_lo;
    logic [RW-1:0]                   r_s1_wrow;
    logic [cml_pkg::CURVE_W-1:0]     r_s1_curve;
    logic [cml_pkg::VAL_W-1:0]       r_s1_val;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_wr    <= in_is_wr;
            r_s1_ok    <= (in_wl > r_min_wl) && (in_wl < r_max_wl);
            r_s1_hi    <= in_off[cml_pkg::WL_W-1:cml_pkg::FRAC_W];
            r_s1_lo    <= in_off[cml_pkg::FRAC_W-1:0];
            r_s1_wrow  <= in_row_ext[RW-1:0];
            r_s1_curve <= in_curve;
            r_s1_val   <= in_val;
        end
    end

    // ---------------------------------------------------------------- stage 2
    // Split the offset into row and remainder: hi / 5 through a reciprocal.
    logic [cml_pkg::HI_PROD_W-1:0] hi_prod;
    logic [cml_pkg::ROW_Q_W-1:0]   q_row;
    logic [QXW-1:0]                q_row_ext;
    logic [cml_pkg::STEP_HI_W-1:0] q_times5;
    logic [cml_pkg::STEP_HI_W-1:0] hi_rem;

    assign hi_prod   = cml_pkg::HI_PROD_W'(r_s1_hi) * cml_pkg::RECIP5_HI;
    assign q_row     = hi_prod[cml_pkg::RECIP5_HI_SH +: cml_pkg::ROW_Q_W];
    assign q_row_ext = QXW'(q_row);
    assign q_times5  = cml_pkg::STEP_HI_W'({q_row, 2'b00}) + cml_pkg::STEP_HI_W'(q_row);
    assign hi_rem    = r_s1_hi - q_times5;

    logic                        r_s2_wr;
    logic                        r_s2_ok;
    logic [RW-1:0]               r_s2_row;
    logic [cml_pkg::REM_W-1:0]   r_s2_rem;
    logic [cml_pkg::CURVE_W-1:0] r_s2_curve;
    logic [cml_pkg::VAL_W-1:0]   r_s2_val;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_wr    <= r_s1_wr;
            r_s2_ok    <= r_s1_ok && ((32'(q_row) + 32'd1) < 32'(TABLE_ROWS));
            r_s2_row   <= r_s1_wr ? r_s1_wrow : q_row_ext[RW-1:0];
            r_s2_rem   <= {hi_rem[2:0], r_s1_lo};
            r_s2_curve <= r_s1_curve;
            r_s2_val   <= r_s1_val;
        end
    end

    // ---------------------------------------------------------------- stage 3: memories
    // The word in stage 2 reads the row pair or writes one entry as it moves on;
    // one access per slot keeps reads and writes in arrival order.
    logic [cml_pkg::VAL_W-1:0] mem_a [NC];
    logic [cml_pkg::VAL_W-1:0] mem_b [NC];

    for (genvar c = 0; c < NC; c++) begin : g_curve
        cml_curve_mem #(
            .TABLE_ROWS (TABLE_ROWS)
        ) u_mem (
            .i_clk     (i_clk),
            .i_wr_en   (en3 && r_s2_valid && r_s2_wr &&
                        (r_s2_curve == cml_pkg::CURVE_W'(c))),
            .i_rd_en   (en3),
            .i_row     (r_s2_row),
            .i_wr_data (r_s2_val),
            .o_a       (mem_a[c]),
            .o_b       (mem_b[c])
        );
    end

    logic                      r_s3_ok;
    logic [cml_pkg::REM_W-1:0] r_s3_rem;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_ok  <= r_s2_ok;
            r_s3_rem <= r_s2_rem;
        end
    end

    // ---------------------------------------------------------------- stage 4: weights
    logic [cml_pkg::REM_W-1:0]  rem_inv;
    logic [cml_pkg::PROD_W-1:0] r_s4_pa [NC];
    logic [cml_pkg::PROD_W-1:0] r_s4_pb [NC];
    logic                       r_s4_ok;

    assign rem_inv = cml_pkg::STEP_FIXED - r_s3_rem;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_ok <= r_s3_ok;
            for (int c = 0; c < NC; c++) begin
                r_s4_pa[c] <= cml_pkg::PROD_W'(mem_a[c]) * cml_pkg::PROD_W'(rem_inv);
                r_s4_pb[c] <= cml_pkg::PROD_W'(mem_b[c]) * cml_pkg::PROD_W'(r_s3_rem);
            end
        end
    end

    // ---------------------------------------------------------------- stage 5: divide by 1280
    // Shift out 256, then divide by 5 through a reciprocal; truncates like the sum.
    logic [cml_pkg::PROD_W-1:0]   blend_sum [NC];
    logic [cml_pkg::QMUL_W-1:0]   blend_q   [NC];
    logic [cml_pkg::VAL_W-1:0]    r_out_val [NC];
    logic                         r_out_in_range;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            blend_sum[c] = r_s4_pa[c] + r_s4_pb[c];
            blend_q[c]   = cml_pkg::QMUL_W'(blend_sum[c][cml_pkg::PROD_W-1:cml_pkg::FRAC_W]) *
                           cml_pkg::RECIP5_LO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_in_range <= r_s4_ok;
            for (int c = 0; c < NC; c++) begin
                r_out_val[c] <= r_s4_ok ? blend_q[c][cml_pkg::RECIP5_LO_SH +: cml_pkg::VAL_W]
                                        : '0;
            end
        end
    end

    // ---------------------------------------------------------------- valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_valid <= accept && (!in_is_wr || in_wr_ok);
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en3) begin
                // Writes retire in the memory stage.
                r_s3_valid <= r_s2_valid && !r_s2_wr;
            end
            if (en4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (en_out) begin
                r_out_valid <= r_s4_valid;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_val[2], r_out_val[1], r_out_val[0]};
    assign o_m_tuser  = r_out_in_range;

    // ---------------------------------------------------------------- assertions
    a_out_of_range_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("out-of-range result carries nonzero curve values");

    a_write_retires : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en3 && r_s2_valid && r_s2_wr) |=> !r_s3_valid)
        else $error("table write leaked past the memory stage");

    a_row_pair_in_table : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_wr && r_s2_ok) |-> ((32'(r_s2_row) + 32'd1) < 32'(TABLE_ROWS)))
        else $error("in-range lookup addresses a row pair beyond the table");

    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_wr) |-> (r_s2_rem < cml_pkg::STEP_FIXED))
        else $error("interpolation remainder out of step range");

    a_stall_from_master : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_valid && !en4) |-> (r_out_valid && !i_m_tready))
        else $error("pipeline stalled without master backpressure");

endmodule

@@ hw/rtl/cml_curve_mem.sv @@
// One curve of the table, split into even and odd row banks for a row-pair read.
module cml_curve_mem #(
    parameter int  TABLE_ROWS = cml_pkg::TABLE_ROWS_DEF,
    localparam int RW         = ($clog2(TABLE_ROWS) < 2) ? 2 : $clog2(TABLE_ROWS)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic                      i_rd_en,
    input  logic [RW-1:0]             i_row,
    input  logic [cml_pkg::VAL_W-1:0] i_wr_data,
    output logic [cml_pkg::VAL_W-1:0] o_a,
    output logic [cml_pkg::VAL_W-1:0] o_b
);

    localparam int AW    = RW - 1;
    localparam int DEPTH = 1 << AW;

    logic [cml_pkg::VAL_W-1:0] r_even_mem [DEPTH];
    logic [cml_pkg::VAL_W-1:0] r_odd_mem  [DEPTH];
    logic [cml_pkg::VAL_W-1:0] r_even_q;
    logic [cml_pkg::VAL_W-1:0] r_odd_q;
    logic                      r_par;
    logic [RW-1:0]             row_plus;

    // Rows r and r+1 always fall in opposite banks.
    assign row_plus = i_row + RW'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (i_row[0]) begin
                r_odd_mem[i_row[RW-1:1]] <= i_wr_data;
            end else begin
                r_even_mem[i_row[RW-1:1]] <= i_wr_data;
            end
        end
        if (i_rd_en) begin
            r_even_q <= r_even_mem[row_plus[RW-1:1]];
            r_odd_q  <= r_odd_mem[i_row[RW-1:1]];
            r_par    <= i_row[0];
        end
    end

    // Put the lower row first.
    assign o_a = r_par ? r_odd_q  : r_even_q;
    assign o_b = r_par ? r_even_q : r_odd_q;

endmodule
